>>> rtl/pwpr_pkg.sv
// Package with the constants, register indexes and types shared by the receiver modules.
package pwpr_pkg;

    localparam int PACKET_BYTES = 8;
    localparam int ADDR_W       = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int TIME_W       = 32;
    localparam int POS_W        = 3;

    localparam logic [CFG_W-1:0] SYNC_MIN_RESET = 16'd2400;
    localparam logic [CFG_W-1:0] ONE_MIN_RESET  = 16'd700;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = 1'd1;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PACKET_BYTES - 1);

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } t_emit_state;

endpackage

>>> rtl/pwpr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pwpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pwpr_decode.sv
// Edge timing, sync detection and bit assembly; completed bytes are written to the packet RAM.
module pwpr_decode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pwpr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pwpr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_line_level,
    input  logic [pwpr_pkg::TIME_W-1:0]    i_time_us,
    output pwpr_pkg::t_wr_req              o_wr,
    output logic                           o_done
);
    import pwpr_pkg::*;

    logic [CFG_W-1:0]  r_sync_min;
    logic [CFG_W-1:0]  r_one_min;
    logic              r_held_level, n_held_level;
    logic [TIME_W-1:0] r_edge_time, n_edge_time;
    logic              r_receiving, n_receiving;
    logic [ADDR_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [2:0]        r_bit_cnt, n_bit_cnt;
    logic              r_start_pend, n_start_pend;
    logic [7:0]        r_shift, n_shift;
    logic [TIME_W-1:0] span;
    logic              bit_val;

    assign span    = i_time_us - r_edge_time;
    assign bit_val = span > {{(TIME_W - CFG_W){1'b0}}, r_one_min};

    always_comb begin
        n_held_level = r_held_level;
        n_edge_time  = r_edge_time;
        n_receiving  = r_receiving;
        n_byte_cnt   = r_byte_cnt;
        n_bit_cnt    = r_bit_cnt;
        n_start_pend = r_start_pend;
        n_shift      = r_shift;
        o_wr.en      = 1'b0;
        o_wr.addr    = r_byte_cnt;
        o_wr.data    = {bit_val, r_shift[7:1]};
        o_done       = 1'b0;
        if (i_accept && (i_line_level != r_held_level)) begin
            n_held_level = i_line_level;
            n_edge_time  = i_time_us;
            if (i_line_level) begin
                if (span > {{(TIME_W - CFG_W){1'b0}}, r_sync_min}) begin
                    n_receiving  = 1'b1;
                    n_byte_cnt   = '0;
                    n_bit_cnt    = '0;
                    n_start_pend = 1'b1;
                end
            end else if (r_receiving) begin
                if (r_start_pend) begin
                    n_start_pend = 1'b0;
                end else begin
                    n_shift = {bit_val, r_shift[7:1]};
                    if (r_bit_cnt == 3'd7) begin
                        n_bit_cnt = '0;
                        o_wr.en   = 1'b1;
                        if (r_byte_cnt == LAST_ADDR) begin
                            o_done      = 1'b1;
                            n_receiving = 1'b0;
                            n_byte_cnt  = '0;
                        end else begin
                            n_byte_cnt = r_byte_cnt + 1'b1;
                        end
                    end else begin
                        n_bit_cnt = r_bit_cnt + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_min   <= SYNC_MIN_RESET;
            r_one_min    <= ONE_MIN_RESET;
            r_held_level <= 1'b1;
            r_edge_time  <= '0;
            r_receiving  <= 1'b0;
            r_byte_cnt   <= '0;
            r_bit_cnt    <= '0;
            r_start_pend <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == REG_SYNC_MIN)) begin
                r_sync_min <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == REG_ONE_MIN)) begin
                r_one_min <= i_cfg_data;
            end
            r_held_level <= n_held_level;
            r_edge_time  <= n_edge_time;
            r_receiving  <= n_receiving;
            r_byte_cnt   <= n_byte_cnt;
            r_bit_cnt    <= n_bit_cnt;
            r_start_pend <= n_start_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    a_done_on_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_wr.en && (o_wr.addr == LAST_ADDR))
        else $error("packet done without the final byte write");

    a_done_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !r_receiving && (r_byte_cnt == '0))
        else $error("reception not stopped after a full packet");

    a_write_needs_rx : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> r_receiving && !r_start_pend && (r_bit_cnt == 3'd7))
        else $error("byte written outside of an active packet");

endmodule

>>> rtl/pwpr_emit.sv
// Packet output sequencer that reads the packet RAM byte by byte into the output channel.
module pwpr_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_out_stall,
    output pwpr_pkg::t_rd_req           o_rd,
    output logic                        o_busy,
    output logic                        o_out_valid,
    output logic [pwpr_pkg::POS_W-1:0]  o_byte_position,
    output logic                        o_last_byte
);
    import pwpr_pkg::*;

    t_emit_state       r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              xfer;

    assign xfer = (r_state == ST_SHOW) && !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pos     = r_pos;
        o_rd.en   = 1'b0;
        o_rd.addr = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_rd.en   = 1'b1;
                o_rd.addr = '0;
                n_idx     = '0;
                n_pos     = '0;
                n_state   = ST_SHOW;
            end
            ST_SHOW: begin
                if (xfer) begin
                    if (r_idx == LAST_ADDR) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_rd.en   = 1'b1;
                        o_rd.addr = r_idx + 1'b1;
                        n_idx     = r_idx + 1'b1;
                        n_pos     = r_pos + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
        end
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_out_valid     = (r_state == ST_SHOW);
    assign o_byte_position = r_pos;
    assign o_last_byte     = (r_idx == LAST_ADDR);

    a_start_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("packet start while a packet is still being sent");

    a_last_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && o_last_byte |=> (r_state == ST_IDLE))
        else $error("sequencer did not stop after the last byte");

    a_next_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && !o_last_byte |=> o_out_valid && (r_idx == $past(r_idx) + 1'b1))
        else $error("next byte not presented after a transfer");

endmodule

>>> rtl/pulse_width_packet_receiver.sv
// Top level of the pulse-width packet receiver.
// The input channel carries line-level change events (i_line_level, i_time_us)
// with i_in_valid and o_in_stall; a transfer happens when valid is high and stall is low.
// Each event is decoded in the cycle it is taken, so the block takes one event per cycle
// while no packet is being sent.
// When the final bit of a packet arrives, the bytes stored in the packet RAM are sent
// on the output channel (o_out_valid, i_out_stall) with position and last mark.
// After the completing event the sequencer starts the first RAM read in its read state
// and shows the byte in its show state; further bytes follow one per cycle while the
// receiver does not stall, since each output transfer starts the next RAM read.
// The next event can be taken in the cycle after the last byte transfer.
// The output data is held in the RAM read register, so a stall simply freezes it.
// The input channel is stalled from the completing event until the last byte transfer.
// The configuration port writes sync_min_us (index 0) and one_min_us (index 1); the user
// must write them only while the block is idle, as the block itself does not enforce it.
// A synchronous active-low reset sets the line level to high, stops reception and
// restores the register defaults; the packet RAM is not cleared.
module pulse_width_packet_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pwpr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pwpr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_line_level,
    input  logic [pwpr_pkg::TIME_W-1:0]    i_time_us,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_data_byte,
    output logic [pwpr_pkg::POS_W-1:0]     o_byte_position,
    output logic                           o_last_byte
);
    import pwpr_pkg::*;

    t_wr_req wr;
    t_rd_req rd;
    logic    done;
    logic    busy;
    logic    accept;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    pwpr_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_line_level (i_line_level),
        .i_time_us    (i_time_us),
        .o_wr         (wr),
        .o_done       (done)
    );

    pwpr_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd.en),
        .i_raddr (rd.addr),
        .o_rdata (o_data_byte)
    );

    pwpr_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (done),
        .i_out_stall     (i_out_stall),
        .o_rd            (rd),
        .o_busy          (busy),
        .o_out_valid     (o_out_valid),
        .o_byte_position (o_byte_position),
        .o_last_byte     (o_last_byte)
    );

endmodule

>>> tb/tb_pulse_width_packet_receiver.sv
// Self-checking testbench for the pulse-width packet receiver with a directed table and random packets.
`timescale 1ns / 1ps

module tb_pulse_width_packet_receiver;
    import pwpr_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SHORT_ITEMS = 6;

    typedef struct {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_rx_byte;

    typedef struct {
        logic              lvl;
        logic [TIME_W-1:0] t;
        int                n_bytes;
    } t_edge_row;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = REG_SYNC_MIN;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic                 i_line_level = 1'b1;
    logic [TIME_W-1:0]    i_time_us    = '0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic [7:0]           o_data_byte;
    logic [POS_W-1:0]     o_byte_position;
    logic                 o_last_byte;

    // Decoder state mirrored by the testbench.
    logic              dec_level;
    logic [TIME_W-1:0] dec_edge_t;
    bit                dec_rx;
    bit                dec_start;
    int unsigned       dec_byte;
    int unsigned       dec_bit;
    logic [7:0]        dec_store [PACKET_BYTES];
    logic [CFG_W-1:0]  dec_sync_min;
    logic [CFG_W-1:0]  dec_one_min;
    int unsigned       sent_cnt = 0;

    t_rx_byte          pending_bytes [$];
    int                err_cnt = 0;
    bit                gaps_on = 1'b1;
    bit                long_hold_req = 1'b0;
    logic [TIME_W-1:0] now_t;

    t_edge_row edge_table [0:21] = '{
        '{1'b1, 32'd5,         0},
        '{1'b0, 32'd100,       0},
        '{1'b1, 32'd2500,      0},
        '{1'b1, 32'd2600,      0},
        '{1'b0, 32'hFFFF_FF00, 0},
        '{1'b1, 32'h0000_0900, 0},
        '{1'b0, 32'h0000_0A00, 0},
        '{1'b1, 32'h0000_0B00, 0},
        '{1'b0, 32'h0000_0DBD, 0},
        '{1'b1, 32'h0000_0E00, 0},
        '{1'b0, 32'h0000_10BC, 0},
        '{1'b0, 32'h0000_2000, 0},
        '{1'b1, 32'h0000_1200, 0},
        '{1'b0, 32'h0000_1200, 0},
        '{1'b1, 32'h0000_1300, 0},
        '{1'b0, 32'hFFFF_FFFF, 0},
        '{1'b1, 32'h0000_0000, 0},
        '{1'b0, 32'h0000_0100, 0},
        '{1'b1, 32'h0000_0A61, 0},
        '{1'b0, 32'h0000_0B00, 0},
        '{1'b1, 32'h0000_0C00, 0},
        '{1'b0, 32'h0000_13D0, 0}
    };

    pulse_width_packet_receiver DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_line_level    (i_line_level),
        .i_time_us       (i_time_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_data_byte     (o_data_byte),
        .o_byte_position (o_byte_position),
        .o_last_byte     (o_last_byte)
    );

    always #2 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= 100) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    // Applies one accepted line event and queues the packet bytes it completes.
    function automatic int decode_edge(input logic lvl, input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] span;
        logic              bitv;
        int                n;
        t_rx_byte          b;
        n = 0;
        if (lvl == dec_level) begin
            return 0;
        end
        span = t - dec_edge_t;
        if (lvl) begin
            if (span > {16'd0, dec_sync_min}) begin
                dec_rx    = 1'b1;
                dec_byte  = 0;
                dec_bit   = 0;
                dec_start = 1'b1;
            end
        end else if (dec_rx) begin
            bitv = (span > {16'd0, dec_one_min});
            if (dec_start) begin
                dec_start = 1'b0;
            end else if (dec_byte < PACKET_BYTES) begin
                if (dec_bit == 0) begin
                    dec_store[dec_byte] = 8'd0;
                end
                dec_store[dec_byte][dec_bit] = bitv;
                if (dec_bit >= 7) begin
                    dec_bit = 0;
                    dec_byte++;
                    if (dec_byte >= PACKET_BYTES) begin
                        for (int k = 0; k < PACKET_BYTES; k++) begin
                            b.data = dec_store[k];
                            b.pos  = POS_W'(k);
                            b.last = (k == PACKET_BYTES - 1);
                            pending_bytes.push_back(b);
                        end
                        n = PACKET_BYTES;
                        dec_rx   = 1'b0;
                        dec_byte = 0;
                    end
                end else begin
                    dec_bit++;
                end
            end
        end
        dec_edge_t = t;
        dec_level  = lvl;
        return n;
    endfunction

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_edge(input logic lvl, input logic [TIME_W-1:0] t, output int produced);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_line_level <= lvl;
        i_time_us    <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        produced = decode_edge(lvl, t);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    // Sync, start bit, then n_bits data bits; fewer than a full packet leaves it broken.
    task automatic send_packet(input int n_bits);
        int   n;
        logic b;
        now_t += $urandom_range(0, 3000);
        send_edge(1'b0, now_t, n);
        if ($urandom_range(0, 3) == 0) begin
            now_t += {16'd0, dec_sync_min} + 1;
        end else begin
            now_t += {16'd0, dec_sync_min} + 1 + $urandom_range(0, 5000);
        end
        send_edge(1'b1, now_t, n);
        for (int i = 0; i <= n_bits; i++) begin
            b = $urandom_range(0, 1);
            if (b) begin
                now_t += {16'd0, dec_one_min} + 1 + $urandom_range(0, 2000);
            end else if ($urandom_range(0, 7) == 0) begin
                now_t += {16'd0, dec_one_min};
            end else begin
                now_t += $urandom_range(0, dec_one_min);
            end
            send_edge(1'b0, now_t, n);
            if (i < n_bits) begin
                if ($urandom_range(0, 7) == 0) begin
                    now_t += {16'd0, dec_sync_min};
                end else begin
                    now_t += $urandom_range(0, dec_sync_min);
                end
                send_edge(1'b1, now_t, n);
            end
        end
    endtask

    task automatic wait_drained();
        int cnt;
        cnt = 0;
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0 && cnt < DRAIN_LIMIT) begin
            @(negedge i_clk);
            cnt++;
        end
        if (pending_bytes.size() != 0) begin
            flag_mismatch($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
            pending_bytes.delete();
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] sync_min, input logic [CFG_W-1:0] one_min);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SYNC_MIN;
        i_cfg_data <= sync_min;
        @(negedge i_clk);
        i_cfg_idx  <= REG_ONE_MIN;
        i_cfg_data <= one_min;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        dec_sync_min = sync_min;
        dec_one_min  = one_min;
    endtask

    always @(posedge i_clk) begin : out_check
        t_rx_byte e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                flag_mismatch($sformatf("unexpected byte %02h pos %0d last %0b",
                                        o_data_byte, o_byte_position, o_last_byte));
            end else begin
                e = pending_bytes.pop_front();
                if (o_data_byte !== e.data || o_byte_position !== e.pos ||
                    o_last_byte !== e.last) begin
                    flag_mismatch($sformatf("got byte %02h pos %0d last %0b, want %02h %0d %0b",
                                            o_data_byte, o_byte_position, o_last_byte,
                                            e.data, e.pos, e.last));
                end
            end
        end
    end

    initial begin : out_stall_gen
        forever begin
            @(posedge i_clk);
            if (long_hold_req && o_out_valid) begin
                long_hold_req = 1'b0;
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int          n;
        int unsigned first_cnt;
        dec_level    = 1'b1;
        dec_edge_t   = '0;
        dec_rx       = 1'b0;
        dec_start    = 1'b0;
        dec_byte     = 0;
        dec_bit      = 0;
        dec_sync_min = SYNC_MIN_RESET;
        dec_one_min  = ONE_MIN_RESET;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (edge_table[r]) begin
            send_edge(edge_table[r].lvl, edge_table[r].t, n);
            if (n != edge_table[r].n_bytes) begin
                flag_mismatch($sformatf("table row %0d yields %0d bytes, want %0d",
                                        r, n, edge_table[r].n_bytes));
            end
        end
        now_t = edge_table[21].t;

        for (int ph = 0; ph < 5; ph++) begin
            if (ph != 0) begin
                wait_drained();
                case (ph)
                    1: begin
                        set_timing(16'd0, 16'd0);
                    end
                    2: begin
                        set_timing(16'hFFFF, 16'hFFFF);
                    end
                    3: begin
                        set_timing(CFG_W'($urandom_range(0, 65535)),
                                   CFG_W'($urandom_range(0, 65535)));
                    end
                    default: begin
                        set_timing(SYNC_MIN_RESET, ONE_MIN_RESET);
                    end
                endcase
            end
            gaps_on = (ph != 4);
            if (ph == 1 || ph == 2) begin
                first_cnt = sent_cnt;
                while (sent_cnt - first_cnt < SHORT_ITEMS) begin
                    if ($urandom_range(0, 1) == 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            now_t = $urandom;
                        end else begin
                            now_t += $urandom_range(0, 100000);
                        end
                        send_edge(1'($urandom_range(0, 1)), now_t, n);
                    end else begin
                        send_packet($urandom_range(0, 3));
                    end
                end
            end else begin
                if (ph == 3) begin
                    long_hold_req = 1'b1;
                end
                send_packet(8 * PACKET_BYTES);
                if (ph == 3) begin
                    now_t += $urandom_range(0, 3000);
                    send_edge(1'b1, now_t, n);
                end
            end
        end

        wait_drained();
        repeat (16) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
